### rtl/srchk_pkg.sv
// shared constants, types and the crc byte update for the save record checker
package srchk_pkg;

    localparam int RECORD_BYTES = 16;
    localparam int FIELD_BASE   = 4;
    localparam int FIELD_DEPTH  = 12;
    localparam int CRC_SPAN     = 14;
    localparam int MAGIC_BYTES  = 4;
    localparam int POS_W        = 5;
    localparam int CFG_INDEX_W  = 4;
    localparam int CFG_DATA_W   = 32;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [CFG_INDEX_W-1:0] REG_MAGIC_WORD     = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_FORMAT_VERSION = CFG_INDEX_W'(1);

    typedef logic [7:0] t_byte;
    typedef logic [POS_W-1:0] t_pos;

    // crc-16/ccitt-false, msb first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input t_byte data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### rtl/srchk_if.sv
// valid/ready channel interfaces: record bytes in, check results out, register writes

interface srchk_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface srchk_out_if;
    logic        valid;
    logic        ready;
    logic        record_ok;
    logic [15:0] scene_id;
    logic [31:0] step_count;
    logic [15:0] music_id;
    modport source (output valid, output record_ok, output scene_id, output step_count,
                    output music_id, input ready);
    modport sink   (input valid, input record_ok, input scene_id, input step_count,
                    input music_id, output ready);
endinterface

interface srchk_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [srchk_pkg::CFG_INDEX_W-1:0] index;
    logic [srchk_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/save_record_checker_crc16_top.sv
// save record checker: byte stream in, one crc-16 checked result per record out
//
// i_in carries one record byte per transfer, last_byte set on the final byte.
// each byte updates the running crc (bytes 0-13), magic compare (bytes 0-3) and
// field store (bytes 4-15) in the transfer cycle; the final byte loads the
// result register, so o_out.valid rises in the cycle after the final byte is
// taken. one byte per cycle is sustained while o_out is drained; the byte-wide
// crc update feeding back into the crc state register sets that figure.
// a record must be 16 bytes: magic (4), version (2), scene (2), step (4),
// music (2), crc (2), all little-endian. shorter records fail, bytes past
// the sixteenth are ignored. on failure record_ok and all fields are zero.
// i_cfg writes magic_word (index 0) and format_version (index 1), always
// ready; other indexes are dropped.
// reset clears all but the field and result data registers; a record restarts.
// a result waiting on a stalled receiver holds i_in.ready low; no byte is lost.
module save_record_checker_crc16_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srchk_in_if.sink   i_in,
    srchk_out_if.source o_out,
    srchk_cfg_if.sink  i_cfg
);
    import srchk_pkg::*;

    localparam t_pos POS_FULL  = POS_W'(RECORD_BYTES);
    localparam t_pos POS_CRC   = POS_W'(CRC_SPAN);
    localparam t_pos POS_MAGIC = POS_W'(MAGIC_BYTES);
    localparam t_pos POS_TAIL  = POS_W'(RECORD_BYTES - 1);

    logic [31:0] r_magic, n_magic;
    logic [15:0] r_version, n_version;
    t_pos        r_pos, n_pos;
    logic [15:0] r_crc, n_crc;
    logic        r_mismatch, n_mismatch;
    t_byte       r_field [FIELD_DEPTH];
    t_byte       n_field [FIELD_DEPTH];

    logic        r_out_valid, n_out_valid;
    logic        r_ok, n_ok;
    logic [15:0] r_scene, n_scene;
    logic [31:0] r_step, n_step;
    logic [15:0] r_music, n_music;

    logic        in_xfer;
    logic        out_xfer;
    logic        in_record;
    logic        byte_bad;
    logic        any_bad;
    logic        len_ok;
    logic        pass;
    t_byte       crc_hi;

    assign out_xfer   = r_out_valid && o_out.ready;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign in_record = (r_pos < POS_FULL);
    assign byte_bad  = (r_pos < POS_MAGIC) &&
                       (r_magic[{r_pos[1:0], 3'b000} +: 8] != i_in.data_byte);
    assign any_bad   = r_mismatch || byte_bad;
    assign len_ok    = (r_pos == POS_TAIL) || (r_pos == POS_FULL);
    // stored crc high byte is the one arriving now when it closes the record
    assign crc_hi    = (r_pos == POS_TAIL) ? i_in.data_byte : r_field[FIELD_DEPTH-1];
    assign pass      = len_ok && !any_bad &&
                       ({r_field[1], r_field[0]} == r_version) &&
                       ({crc_hi, r_field[FIELD_DEPTH-2]} == r_crc);

    always_comb begin
        n_magic     = r_magic;
        n_version   = r_version;
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_mismatch  = r_mismatch;
        n_field     = r_field;
        n_out_valid = r_out_valid;
        n_ok        = r_ok;
        n_scene     = r_scene;
        n_step      = r_step;
        n_music     = r_music;

        if (i_cfg.valid) begin
            if (i_cfg.index == REG_MAGIC_WORD) begin
                n_magic = i_cfg.data;
            end else if (i_cfg.index == REG_FORMAT_VERSION) begin
                n_version = i_cfg.data[15:0];
            end
        end

        if (out_xfer) begin
            n_out_valid = 1'b0;
        end

        if (in_xfer) begin
            if (in_record) begin
                n_mismatch = any_bad;
                for (int k = 0; k < FIELD_DEPTH; k++) begin
                    if (r_pos == POS_W'(FIELD_BASE + k)) begin
                        n_field[k] = i_in.data_byte;
                    end
                end
                if (r_pos < POS_CRC) begin
                    n_crc = crc_byte(r_crc, i_in.data_byte);
                end
                n_pos = r_pos + POS_W'(1);
            end
            if (i_in.last_byte) begin
                n_out_valid = 1'b1;
                n_ok        = pass;
                n_scene     = pass ? {r_field[3], r_field[2]} : 16'h0000;
                n_step      = pass ? {r_field[7], r_field[6], r_field[5], r_field[4]}
                                   : 32'h0000_0000;
                n_music     = pass ? {r_field[9], r_field[8]} : 16'h0000;
                n_pos       = '0;
                n_crc       = CRC_INIT;
                n_mismatch  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic     <= '0;
            r_version   <= '0;
            r_pos       <= '0;
            r_crc       <= CRC_INIT;
            r_mismatch  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_magic     <= n_magic;
            r_version   <= n_version;
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_mismatch  <= n_mismatch;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_field <= n_field;
        r_ok    <= n_ok;
        r_scene <= n_scene;
        r_step  <= n_step;
        r_music <= n_music;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.record_ok  = r_ok;
    assign o_out.scene_id   = r_scene;
    assign o_out.step_count = r_step;
    assign o_out.music_id   = r_music;

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_FULL)
        else $error("byte position past record length");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in.last_byte |=> r_out_valid && r_pos == '0 && r_crc == CRC_INIT
                                      && !r_mismatch)
        else $error("final byte did not load a result and restart the record");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_ok |-> r_scene == '0 && r_step == '0 && r_music == '0)
        else $error("failed record shows nonzero fields");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_out_valid && !o_out.ready)
        else $error("input stalled without a pending result");

    a_byte_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && !i_in.last_byte && in_record |=> r_pos == $past(r_pos) + POS_W'(1))
        else $error("byte position did not advance");

endmodule

### dv/srchk_tb_pkg.sv
// result prediction and scoreboard for the save record checker testbench
package srchk_tb_pkg;
    import srchk_pkg::*;

    typedef t_byte t_byte_q[$];

    typedef struct packed {
        logic        ok;
        logic [15:0] scene;
        logic [31:0] steps;
        logic [15:0] music;
    } t_check_result;

    // bit-serial form of the ccitt-false update, msb of the data first
    function automatic logic [15:0] crc16_ccitt_step(input logic [15:0] crc, input t_byte value);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int i = 7; i >= 0; i--) begin
            fb  = acc[15] ^ value[i];
            acc = {acc[14:0], 1'b0};
            if (fb) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    class record_checker_sb;
        logic [31:0]   magic_word;
        logic [15:0]   format_version;
        t_pos          taken;
        logic [15:0]   crc_acc;
        bit            magic_bad;
        t_byte         body[FIELD_DEPTH];
        t_check_result pending[$];
        int unsigned   errors;

        function new();
            magic_word     = '0;
            format_version = '0;
            errors         = 0;
            foreach (body[i]) begin
                body[i] = '0;
            end
            restart();
        endfunction

        function void restart();
            taken     = '0;
            crc_acc   = CRC_INIT;
            magic_bad = 1'b0;
        endfunction

        function void note_write(input logic [CFG_INDEX_W-1:0] index,
                                 input logic [CFG_DATA_W-1:0] value);
            case (index)
                REG_MAGIC_WORD:     magic_word = value;
                REG_FORMAT_VERSION: format_version = value[15:0];
                default: ;
            endcase
        endfunction

        function void note_byte(input t_byte value, input logic last);
            t_check_result res;
            // bytes past the sixteenth leave the state alone
            if (taken < RECORD_BYTES) begin
                if (taken < MAGIC_BYTES) begin
                    if (value != magic_word[8*taken +: 8]) begin
                        magic_bad = 1'b1;
                    end
                end else begin
                    body[taken - FIELD_BASE] = value;
                end
                if (taken < CRC_SPAN) begin
                    crc_acc = crc16_ccitt_step(crc_acc, value);
                end
                taken++;
            end
            if (last) begin
                res    = '0;
                res.ok = (taken == RECORD_BYTES) && !magic_bad
                         && ({body[1], body[0]} == format_version)
                         && ({body[11], body[10]} == crc_acc);
                if (res.ok) begin
                    res.scene = {body[3], body[2]};
                    res.steps = {body[7], body[6], body[5], body[4]};
                    res.music = {body[9], body[8]};
                end
                pending.push_back(res);
                restart();
            end
        endfunction

        task report(input string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(input logic ok, input logic [15:0] scene,
                          input logic [31:0] steps, input logic [15:0] music);
            t_check_result want;
            if (pending.size() == 0) begin
                report($sformatf("result with nothing pending, ok=%0b", ok));
                return;
            end
            want = pending.pop_front();
            if (ok !== want.ok) begin
                report($sformatf("record_ok %0b, predicted %0b", ok, want.ok));
            end
            if (scene !== want.scene) begin
                report($sformatf("scene_id %h, predicted %h", scene, want.scene));
            end
            if (steps !== want.steps) begin
                report($sformatf("step_count %h, predicted %h", steps, want.steps));
            end
            if (music !== want.music) begin
                report($sformatf("music_id %h, predicted %h", music, want.music));
            end
        endtask

        task close_out();
            if (pending.size() != 0) begin
                report($sformatf("%0d results never arrived", pending.size()));
            end
        endtask
    endclass

endpackage

### dv/save_record_checker_crc16_top_tb.sv
// testbench top: drives records and register writes, checks every result against the predictor
module save_record_checker_crc16_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srchk_pkg::*;
    import srchk_tb_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LAST = '1;

    typedef enum int {
        REC_GOOD,
        REC_BAD_MAGIC,
        REC_BAD_BODY,
        REC_SHORT,
        REC_LONG,
        REC_NOISE
    } rec_kind_e;

    logic i_clk = 1'b0;
    logic i_rst_n;

    srchk_in_if  in_ch();
    srchk_out_if out_ch();
    srchk_cfg_if cfg_ch();

    record_checker_sb sb = new();

    logic [31:0] cur_magic;
    logic [15:0] cur_version;
    bit          tx_steady;
    bit          rx_steady;
    bit          rx_hold_req;

    save_record_checker_crc16_top i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                sb.check_result(out_ch.record_ok, out_ch.scene_id, out_ch.step_count,
                                out_ch.music_id);
            end
            if (in_ch.valid && in_ch.ready) begin
                sb.note_byte(in_ch.data_byte, in_ch.last_byte);
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                sb.note_write(cfg_ch.index, cfg_ch.data);
            end
        end
    end

    function automatic logic [31:0] rand_field();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_byte_q make_record(input logic [31:0] magic, input logic [15:0] version,
                                            input logic [15:0] scene, input logic [31:0] steps,
                                            input logic [15:0] music);
        t_byte_q     rec;
        logic [15:0] crc;
        for (int i = 0; i < 4; i++) begin
            rec.push_back(magic[8*i +: 8]);
        end
        rec.push_back(version[7:0]);
        rec.push_back(version[15:8]);
        rec.push_back(scene[7:0]);
        rec.push_back(scene[15:8]);
        for (int i = 0; i < 4; i++) begin
            rec.push_back(steps[8*i +: 8]);
        end
        rec.push_back(music[7:0]);
        rec.push_back(music[15:8]);
        crc = CRC_INIT;
        for (int i = 0; i < CRC_SPAN; i++) begin
            crc = crc16_ccitt_step(crc, rec[i]);
        end
        rec.push_back(crc[7:0]);
        rec.push_back(crc[15:8]);
        return rec;
    endfunction

    // valid stays high straight into the next byte when no gap is drawn
    task automatic send_byte(input t_byte value, input logic last);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= value;
        in_ch.last_byte <= last;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
    endtask

    task automatic send_record(input t_byte_q rec);
        foreach (rec[i]) begin
            send_byte(rec[i], i == rec.size() - 1);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        if (index == REG_MAGIC_WORD) begin
            cur_magic = value;
        end else if (index == REG_FORMAT_VERSION) begin
            cur_version = value[15:0];
        end
    endtask

    task automatic cfg_done();
        cfg_ch.valid <= 1'b0;
    endtask

    // sender pauses until every result is back, then lets a byte without result finish
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_record();
        t_byte_q   rec;
        rec_kind_e kind;
        int        draw;
        draw = $urandom_range(0, 9);
        kind = (draw < 5) ? REC_GOOD : rec_kind_e'(draw - 4);
        rec  = make_record(cur_magic, cur_version, 16'(rand_field()), rand_field(),
                           16'(rand_field()));
        case (kind)
            REC_BAD_MAGIC: rec[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
            REC_BAD_BODY:  rec[$urandom_range(4, 15)] ^= 8'(1 << $urandom_range(0, 7));
            REC_SHORT:     rec = rec[0:$urandom_range(0, 14)];
            REC_LONG: begin
                repeat ($urandom_range(1, 4)) rec.push_back(8'($urandom()));
            end
            REC_NOISE: begin
                rec.delete();
                repeat ($urandom_range(1, 20)) rec.push_back(8'($urandom()));
            end
            default: ;
        endcase
        send_record(rec);
    endtask

    initial begin : rx_side
        int hold;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            hold = rx_steady ? 0 : $urandom_range(0, 17);
            // long back-pressure so the result register fills and input stalls
            if (rx_hold_req) begin
                hold        = 300;
                rx_hold_req = 1'b0;
            end
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
        end
    end

    initial begin : stimulus
        t_byte_q     rec;
        logic [31:0] m_old;
        logic [31:0] m_new;
        logic [15:0] v_new;
        int          guard;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.last_byte <= 1'b0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= '0;
        cfg_ch.data     <= '0;
        i_rst_n         <= 1'b0;
        cur_magic   = '0;
        cur_version = '0;
        tx_steady   = 1'b0;
        rx_steady   = 1'b0;
        rx_hold_req = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: registers at reset values
        rec = '{8'hFF};
        send_record(rec);
        send_record(make_record('0, '0, '1, '1, '1));
        rec = make_record('0, '0, '0, '0, '0);
        rec.push_back(8'hFF);
        rec.push_back(8'h00);
        send_record(rec);
        settle();
        write_reg(REG_MAGIC_WORD, '1);
        write_reg(REG_FORMAT_VERSION, 32'h0000_FFFF);
        cfg_done();
        send_record(make_record(cur_magic, cur_version, 16'h1234, 32'h89AB_CDEF, 16'h5A5A));
        rec = make_record(cur_magic, cur_version, 16'h0001, 32'h0000_0002, 16'h0003);
        rec[15] ^= 8'h80;
        send_record(rec);

        for (int ph = 0; ph < 4; ph++) begin
            settle();
            write_reg(REG_UNMAPPED_LAST, $urandom());
            write_reg(CFG_INDEX_W'($urandom_range(int'(REG_FORMAT_VERSION) + 1,
                                                  int'(REG_UNMAPPED_LAST))), $urandom());
            if (ph == 2) begin
                write_reg(REG_MAGIC_WORD, '0);
                write_reg(REG_FORMAT_VERSION, '0);
            end else begin
                write_reg(REG_MAGIC_WORD, $urandom());
                write_reg(REG_FORMAT_VERSION, $urandom());
            end
            cfg_done();
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            if (ph == 1) begin
                tx_steady   = 1'b1;
                rx_hold_req = 1'b1;
            end
            repeat (5) random_record();
        end

        // registers rewritten inside a record: magic after the second byte, version after the sixth
        settle();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        m_old = $urandom();
        m_new = $urandom();
        v_new = 16'($urandom());
        write_reg(REG_MAGIC_WORD, m_old);
        write_reg(REG_FORMAT_VERSION, 32'(~v_new));
        cfg_done();
        rec = make_record({m_new[31:16], m_old[15:0]}, v_new, 16'(rand_field()), rand_field(),
                          16'(rand_field()));
        send_byte(rec[0], 1'b0);
        send_byte(rec[1], 1'b0);
        settle();
        write_reg(REG_MAGIC_WORD, m_new);
        cfg_done();
        for (int i = 2; i < 6; i++) begin
            send_byte(rec[i], 1'b0);
        end
        settle();
        write_reg(REG_FORMAT_VERSION, 32'(v_new));
        cfg_done();
        for (int i = 6; i < RECORD_BYTES; i++) begin
            send_byte(rec[i], i == RECORD_BYTES - 1);
        end
        repeat (4) random_record();

        in_ch.valid <= 1'b0;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        sb.close_out();
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
